FILE: rtl/core/czls_pkg.sv
package czls_pkg;

    localparam int WINDOW_CHARS = 9;
    // one character beyond the window: the passes can cut seven and then read three more
    localparam int KEEP_CHARS   = WINDOW_CHARS + 1;
    localparam int IDX_W        = $clog2(KEEP_CHARS);
    localparam int CUT_W        = 3;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam logic [15:0] CH_A = 16'h0061;
    localparam logic [15:0] CH_C = 16'h0063;
    localparam logic [15:0] CH_E = 16'h0065;
    localparam logic [15:0] CH_H = 16'h0068;
    localparam logic [15:0] CH_I = 16'h0069;
    localparam logic [15:0] CH_K = 16'h006B;
    localparam logic [15:0] CH_M = 16'h006D;
    localparam logic [15:0] CH_N = 16'h006E;
    localparam logic [15:0] CH_O = 16'h006F;
    localparam logic [15:0] CH_S = 16'h0073;
    localparam logic [15:0] CH_T = 16'h0074;
    localparam logic [15:0] CH_U = 16'h0075;
    localparam logic [15:0] CH_V = 16'h0076;
    localparam logic [15:0] CH_Y = 16'h0079;
    localparam logic [15:0] CH_Z = 16'h007A;

    localparam logic [15:0] E_CARON = 16'h011B;
    localparam logic [15:0] U_RING  = 16'h016F;
    localparam logic [15:0] I_ACUTE = 16'h00ED;
    localparam logic [15:0] E_ACUTE = 16'h00E9;
    localparam logic [15:0] A_ACUTE = 16'h00E1;
    localparam logic [15:0] Y_ACUTE = 16'h00FD;
    localparam logic [15:0] C_CARON = 16'h010D;
    localparam logic [15:0] S_CARON = 16'h0161;
    localparam logic [15:0] Z_CARON = 16'h017E;

    localparam logic [15:0] SFX5 [5] = '{CH_A, CH_T, CH_E, CH_C, CH_H};

    localparam logic [15:0] SFX4 [3][4] = '{
        '{E_CARON, CH_T, CH_E, CH_M},
        '{CH_E, CH_T, CH_E, CH_M},
        '{CH_A, CH_T, U_RING, CH_M}
    };

    localparam logic [15:0] SFX3 [25][3] = '{
        '{CH_E, CH_C, CH_H},    '{CH_I, CH_C, CH_H},    '{I_ACUTE, CH_C, CH_H},
        '{E_ACUTE, CH_H, CH_O}, '{E_CARON, CH_M, CH_I}, '{CH_E, CH_M, CH_I},
        '{E_ACUTE, CH_M, CH_U}, '{E_CARON, CH_T, CH_E}, '{CH_E, CH_T, CH_E},
        '{E_CARON, CH_T, CH_I}, '{CH_E, CH_T, CH_I},    '{I_ACUTE, CH_H, CH_O},
        '{CH_I, CH_H, CH_O},    '{I_ACUTE, CH_M, CH_I}, '{I_ACUTE, CH_M, CH_U},
        '{CH_I, CH_M, CH_U},    '{A_ACUTE, CH_C, CH_H}, '{CH_A, CH_T, CH_A},
        '{CH_A, CH_T, CH_Y},    '{Y_ACUTE, CH_C, CH_H}, '{CH_A, CH_M, CH_A},
        '{CH_A, CH_M, CH_I},    '{CH_O, CH_V, E_ACUTE}, '{CH_O, CH_V, CH_I},
        '{Y_ACUTE, CH_M, CH_I}
    };

    localparam logic [15:0] SFX2 [12][2] = '{
        '{CH_E, CH_M}, '{CH_E, CH_S}, '{E_ACUTE, CH_M}, '{I_ACUTE, CH_M},
        '{U_RING, CH_M}, '{CH_A, CH_T}, '{A_ACUTE, CH_M}, '{CH_O, CH_S},
        '{CH_U, CH_S}, '{Y_ACUTE, CH_M}, '{CH_M, CH_I}, '{CH_O, CH_U}
    };

    localparam logic [15:0] VOWELS [12] = '{
        CH_A, CH_E, CH_I, CH_O, CH_U, U_RING, CH_Y, A_ACUTE, E_ACUTE, I_ACUTE,
        Y_ACUTE, E_CARON
    };

    // entry 0 is the word's last character, entry 1 the one before, and so on
    typedef logic [KEEP_CHARS-1:0][15:0] win_t;

    typedef struct packed {
        logic [15:0] ch;
        logic        word_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] stem_length;
        logic [15:0] second_last_char;
        logic [15:0] last_char;
    } out_item_t;

    // one finished word, case ending already classified
    typedef struct packed {
        win_t             win;
        logic [15:0]      case_len;
        logic [CUT_W-1:0] case_cut;
    } word_rec_t;

    // number of characters the case pass removes from a word of length m
    function automatic logic [CUT_W-1:0] case_cut(win_t w, logic [15:0] m);
        logic hit5;
        logic hit4;
        logic hit3;
        logic hit2;
        logic hit1;
        logic [CUT_W-1:0] cut;
        hit5 = 1'b1;
        hit4 = 1'b0;
        hit3 = 1'b0;
        hit2 = 1'b0;
        hit1 = 1'b0;
        for (int i = 0; i < 5; i++)
        begin
            if (w[4-i] != SFX5[i])
                hit5 = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (w[3] == SFX4[i][0] && w[2] == SFX4[i][1] &&
                w[1] == SFX4[i][2] && w[0] == SFX4[i][3])
                hit4 = 1'b1;
        end
        for (int i = 0; i < 25; i++)
        begin
            if (w[2] == SFX3[i][0] && w[1] == SFX3[i][1] && w[0] == SFX3[i][2])
                hit3 = 1'b1;
        end
        for (int i = 0; i < 12; i++)
        begin
            if (w[1] == SFX2[i][0] && w[0] == SFX2[i][1])
                hit2 = 1'b1;
            if (w[0] == VOWELS[i])
                hit1 = 1'b1;
        end
        if (m > 16'd7 && hit5)
            cut = CUT_W'(5);
        else if (m > 16'd6 && hit4)
            cut = CUT_W'(4);
        else if (m > 16'd5 && hit3)
            cut = CUT_W'(3);
        else if (m > 16'd4 && hit2)
            cut = CUT_W'(2);
        else if (m > 16'd3 && hit1)
            cut = CUT_W'(1);
        else
            cut = '0;
        return cut;
    endfunction

endpackage

FILE: rtl/core/czls_front.sv
module czls_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  czls_pkg::in_item_t   char_data,
    input  logic                 queue_full,
    output logic                 push,
    output czls_pkg::word_rec_t  push_data
);
    import czls_pkg::*;

    win_t        win_reg;
    win_t        win_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic        take;

    assign char_ready = !queue_full;
    assign take       = char_valid && char_ready;

    always_comb
    begin
        win_next[0] = char_data.ch;
        for (int j = 1; j < KEEP_CHARS; j++)
            win_next[j] = win_reg[j-1];
        len_next = (len_reg == LEN_MAX) ? len_reg : len_reg + 16'd1;
    end

    assign push               = take && char_data.word_end;
    assign push_data.win      = win_next;
    assign push_data.case_len = len_next - 16'(case_cut(win_next, len_next));
    assign push_data.case_cut = case_cut(win_next, len_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            len_reg <= '0;
        end
        else if (take)
        begin
            // clear for the next word once its last beat is in
            if (char_data.word_end)
            begin
                win_reg <= '0;
                len_reg <= '0;
            end
            else
            begin
                win_reg <= win_next;
                len_reg <= len_next;
            end
        end
    end

    a_word_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> len_reg == 16'd0)
        else $error("length not cleared after word end");

endmodule

FILE: rtl/core/czls_queue.sv
module czls_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  czls_pkg::word_rec_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output czls_pkg::word_rec_t  head
);
    import czls_pkg::*;

    word_rec_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: rtl/core/czls_back.sv
module czls_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  czls_pkg::word_rec_t  head,
    output logic                 pop,
    output logic                 stem_valid,
    input  logic                 stem_ready,
    output czls_pkg::out_item_t  stem_data
);
    import czls_pkg::*;

    logic             out_valid_reg;
    out_item_t        out_data_reg;
    out_item_t        out_data_next;
    logic [15:0]      sv [2];
    logic [15:0]      nv [3];
    logic             poss;
    logic [CUT_W-1:0] cut2;
    logic [15:0]      m2;

    assign pop        = head_valid && (!out_valid_reg || stem_ready);
    assign stem_valid = out_valid_reg;
    assign stem_data  = out_data_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
            sv[j] = head.win[IDX_W'(head.case_cut) + IDX_W'(j)];
        poss = (head.case_len > 16'd5) &&
               ((sv[1] == CH_O && sv[0] == CH_V) ||
                (sv[1] == CH_I && sv[0] == CH_N) ||
                (sv[1] == U_RING && sv[0] == CH_V));
        cut2 = poss ? head.case_cut + CUT_W'(2) : head.case_cut;
        m2   = poss ? head.case_len - 16'd2 : head.case_len;
        for (int j = 0; j < 3; j++)
            nv[j] = head.win[IDX_W'(cut2) + IDX_W'(j)];

        out_data_next.stem_length      = m2;
        out_data_next.last_char        = nv[0];
        out_data_next.second_last_char = (m2 >= 16'd2) ? nv[1] : 16'h0000;
        if (m2 == 16'd0)
        begin
            out_data_next.last_char        = 16'h0000;
            out_data_next.second_last_char = 16'h0000;
        end
        else if (m2 >= 16'd2 && nv[1] == C_CARON && nv[0] == CH_T)
        begin
            out_data_next.second_last_char = CH_C;
            out_data_next.last_char        = CH_K;
        end
        else if (m2 >= 16'd2 && nv[1] == S_CARON && nv[0] == CH_T)
        begin
            out_data_next.second_last_char = CH_S;
            out_data_next.last_char        = CH_K;
        end
        else if (nv[0] == CH_C || nv[0] == C_CARON)
        begin
            out_data_next.last_char = CH_K;
        end
        else if (nv[0] == CH_Z || nv[0] == Z_CARON)
        begin
            out_data_next.last_char = CH_H;
        end
        else if (m2 > 16'd1 && nv[1] == CH_E)
        begin
            // drop the e, the last character moves down one place
            out_data_next.stem_length      = m2 - 16'd1;
            out_data_next.second_last_char = (m2 >= 16'd3) ? nv[2] : 16'h0000;
        end
        else if (m2 > 16'd2 && nv[1] == U_RING)
        begin
            out_data_next.second_last_char = CH_O;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (stem_ready)
            out_valid_reg <= 1'b0;
    end

    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop))
        else $error("result appeared without a queued word");

endmodule

FILE: rtl/core/czech_light_stemmer.sv
// Light Czech stemmer. Feed one UTF-16 character per beat on the char channel and
// mark the last character of each word with word_end; one result per word comes out
// on the stem channel with the stem length and the stem's last two characters after
// case, possessive and ending normalization. The block takes one character every
// cycle unless the queue is full. On a word's last character the front end
// writes the classified word into a two-entry queue, and the back end finishes the
// passes into the output register. The queue and output register absorb
// back-pressure; char_ready drops only when the queue is full. Word length saturates
// at 65535; the passes always act on the true ending of the word.
module czech_light_stemmer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  czls_pkg::in_item_t   char_data,
    output logic                 stem_valid,
    input  logic                 stem_ready,
    output czls_pkg::out_item_t  stem_data
);
    import czls_pkg::*;

    logic      push;
    word_rec_t push_data;
    logic      queue_full;
    logic      pop;
    logic      head_valid;
    word_rec_t head;

    czls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    czls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    czls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .stem_valid (stem_valid),
        .stem_ready (stem_ready),
        .stem_data  (stem_data)
    );

endmodule

FILE: test/stem_checker.sv
`timescale 1ns / 100ps

module stem_checker
    import czls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    input  logic      char_ready,
    input  in_item_t  char_data,
    input  logic      stem_valid,
    input  logic      stem_ready,
    input  out_item_t stem_data,
    output int        mismatches,
    output int        stems_owed
);

    // window plus the character just ahead of it
    localparam int HELD = WINDOW_CHARS + 1;

    localparam logic [15:0] CASE5 [5] = '{CH_A, CH_T, CH_E, CH_C, CH_H};

    localparam logic [15:0] CASE4 [3][4] = '{
        '{E_CARON, CH_T, CH_E, CH_M},
        '{CH_E, CH_T, CH_E, CH_M},
        '{CH_A, CH_T, U_RING, CH_M}
    };

    localparam logic [15:0] CASE3 [25][3] = '{
        '{CH_E, CH_C, CH_H},    '{CH_I, CH_C, CH_H},    '{I_ACUTE, CH_C, CH_H},
        '{E_ACUTE, CH_H, CH_O}, '{E_CARON, CH_M, CH_I}, '{CH_E, CH_M, CH_I},
        '{E_ACUTE, CH_M, CH_U}, '{E_CARON, CH_T, CH_E}, '{CH_E, CH_T, CH_E},
        '{E_CARON, CH_T, CH_I}, '{CH_E, CH_T, CH_I},    '{I_ACUTE, CH_H, CH_O},
        '{CH_I, CH_H, CH_O},    '{I_ACUTE, CH_M, CH_I}, '{I_ACUTE, CH_M, CH_U},
        '{CH_I, CH_M, CH_U},    '{A_ACUTE, CH_C, CH_H}, '{CH_A, CH_T, CH_A},
        '{CH_A, CH_T, CH_Y},    '{Y_ACUTE, CH_C, CH_H}, '{CH_A, CH_M, CH_A},
        '{CH_A, CH_M, CH_I},    '{CH_O, CH_V, E_ACUTE}, '{CH_O, CH_V, CH_I},
        '{Y_ACUTE, CH_M, CH_I}
    };

    localparam logic [15:0] CASE2 [12][2] = '{
        '{CH_E, CH_M}, '{CH_E, CH_S}, '{E_ACUTE, CH_M}, '{I_ACUTE, CH_M},
        '{U_RING, CH_M}, '{CH_A, CH_T}, '{A_ACUTE, CH_M}, '{CH_O, CH_S},
        '{CH_U, CH_S}, '{Y_ACUTE, CH_M}, '{CH_M, CH_I}, '{CH_O, CH_U}
    };

    localparam logic [15:0] VOWEL1 [12] = '{
        CH_A, CH_E, CH_I, CH_O, CH_U, U_RING, CH_Y, A_ACUTE, E_ACUTE, I_ACUTE,
        Y_ACUTE, E_CARON
    };

    logic [15:0] hist [HELD];   // hist[HELD-1] is the newest character
    int          seen;          // saturating word length
    out_item_t   stem_q [$];
    int          errors;

    // character at word position pos, zero when not held
    function automatic logic [15:0] char_at(int pos);
        int d;
        d = seen - 1 - pos;
        if (pos < 0 || pos >= seen || d >= HELD)
            return 16'h0000;
        return hist[HELD-1-d];
    endfunction

    function automatic void put_char(int pos, logic [15:0] c);
        int d;
        d = seen - 1 - pos;
        if (pos >= 0 && pos < seen && d < HELD)
            hist[HELD-1-d] = c;
    endfunction

    function automatic bit ends_pair(int m, logic [15:0] a, logic [15:0] b);
        return m >= 2 && char_at(m - 2) == a && char_at(m - 1) == b;
    endfunction

    function automatic int cut_case(int m);
        bit hit;
        if (m > 7)
        begin
            hit = 1'b1;
            for (int k = 0; k < 5; k++)
            begin
                if (char_at(m - 5 + k) != CASE5[k])
                    hit = 1'b0;
            end
            if (hit)
                return m - 5;
        end
        if (m > 6)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hit = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    if (char_at(m - 4 + k) != CASE4[i][k])
                        hit = 1'b0;
                end
                if (hit)
                    return m - 4;
            end
        end
        if (m > 5)
        begin
            for (int i = 0; i < 25; i++)
            begin
                if (char_at(m - 3) == CASE3[i][0] && ends_pair(m, CASE3[i][1], CASE3[i][2]))
                    return m - 3;
            end
        end
        if (m > 4)
        begin
            for (int i = 0; i < 12; i++)
            begin
                if (ends_pair(m, CASE2[i][0], CASE2[i][1]))
                    return m - 2;
            end
        end
        if (m > 3)
        begin
            for (int i = 0; i < 12; i++)
            begin
                if (char_at(m - 1) == VOWEL1[i])
                    return m - 1;
            end
        end
        return m;
    endfunction

    function automatic int cut_possessive(int m);
        if (m > 5 && (ends_pair(m, CH_O, CH_V) || ends_pair(m, CH_I, CH_N) ||
                      ends_pair(m, U_RING, CH_V)))
            return m - 2;
        return m;
    endfunction

    function automatic int fix_end(int m);
        logic [15:0] c;
        if (m == 0)
            return m;
        if (ends_pair(m, C_CARON, CH_T))
        begin
            put_char(m - 2, CH_C);
            put_char(m - 1, CH_K);
            return m;
        end
        if (ends_pair(m, S_CARON, CH_T))
        begin
            put_char(m - 2, CH_S);
            put_char(m - 1, CH_K);
            return m;
        end
        c = char_at(m - 1);
        if (c == CH_C || c == C_CARON)
        begin
            put_char(m - 1, CH_K);
            return m;
        end
        if (c == CH_Z || c == Z_CARON)
        begin
            put_char(m - 1, CH_H);
            return m;
        end
        // drop the e ahead of the last character
        if (m > 1 && char_at(m - 2) == CH_E)
        begin
            put_char(m - 2, c);
            return m - 1;
        end
        if (m > 2 && char_at(m - 2) == U_RING)
        begin
            put_char(m - 2, CH_O);
            return m;
        end
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        int        m;
        if (!rst_n)
        begin
            for (int i = 0; i < HELD; i++)
                hist[i] = 16'h0000;
            seen = 0;
            errors = 0;
            stem_q.delete();
        end
        else
        begin
            if (stem_valid && stem_ready)
            begin
                if (stem_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: stem beat with none owed: len %h chars %h %h", $realtime,
                                 stem_data.stem_length, stem_data.second_last_char,
                                 stem_data.last_char);
                end
                else
                begin
                    want = stem_q.pop_front();
                    if (stem_data.stem_length !== want.stem_length ||
                        stem_data.second_last_char !== want.second_last_char ||
                        stem_data.last_char !== want.last_char)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: stem exp len %h chars %h %h, got len %h chars %h %h",
                                     $realtime, want.stem_length, want.second_last_char,
                                     want.last_char, stem_data.stem_length,
                                     stem_data.second_last_char, stem_data.last_char);
                    end
                end
            end
            if (char_valid && char_ready)
            begin
                for (int i = 0; i < HELD - 1; i++)
                    hist[i] = hist[i+1];
                hist[HELD-1] = char_data.ch;
                if (seen < 65535)
                    seen++;
                if (char_data.word_end)
                begin
                    m = fix_end(cut_possessive(cut_case(seen)));
                    want.stem_length      = 16'(m);
                    want.second_last_char = (m >= 2) ? char_at(m - 2) : 16'h0000;
                    want.last_char        = char_at(m - 1);
                    stem_q.push_back(want);
                    for (int i = 0; i < HELD; i++)
                        hist[i] = 16'h0000;
                    seen = 0;
                end
            end
        end
        stems_owed <= stem_q.size();
        mismatches <= errors;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import czls_pkg::*;

    localparam logic [15:0] LETTERS [24] = '{
        CH_A, CH_C, CH_E, CH_H, CH_I, CH_K, CH_M, CH_N, CH_O, CH_S, CH_T, CH_U,
        CH_V, CH_Y, CH_Z, E_CARON, U_RING, I_ACUTE, E_ACUTE, A_ACUTE, Y_ACUTE,
        C_CARON, S_CARON, Z_CARON
    };

    logic      clk;
    logic      rst_n;
    logic      char_valid;
    logic      char_ready;
    in_item_t  char_data;
    logic      stem_valid;
    logic      stem_ready;
    out_item_t stem_data;
    int        mismatches;
    int        stems_owed;
    bit        calm;    // no idling on either side for the current word
    int        chars_sent;

    czech_light_stemmer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .stem_valid (stem_valid),
        .stem_ready (stem_ready),
        .stem_data  (stem_data)
    );

    stem_checker CHK (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .stem_valid (stem_valid),
        .stem_ready (stem_ready),
        .stem_data  (stem_data),
        .mismatches (mismatches),
        .stems_owed (stems_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [15:0] pick_char();
        if ($urandom_range(0, 6) == 0)
            return 16'($urandom_range(0, 65535));
        return LETTERS[$urandom_range(0, 23)];
    endfunction

    task automatic send_char(input logic [15:0] c, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= '{ch: c, word_end: last};
        do
            @(posedge clk);
        while (!char_ready);
        chars_sent++;
    endtask

    task automatic send_word(input logic [15:0] w [$]);
        for (int i = 0; i < w.size(); i++)
            send_char(w[i], i == w.size() - 1);
    endtask

    // hold the sender until every owed stem has come back
    task automatic drain();
        char_valid <= 1'b0;
        @(posedge clk);
        while (stems_owed != 0)
            @(posedge clk);
    endtask

    // random stem, then maybe a possessive, then maybe a case ending
    task automatic send_random_word();
        logic [15:0] w [$];
        int          base;
        int          i;
        base = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
        repeat (base) w.push_back(pick_char());
        if ($urandom_range(0, 2) == 0)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    w.push_back(CH_O);
                    w.push_back(CH_V);
                end
                1:
                begin
                    w.push_back(CH_I);
                    w.push_back(CH_N);
                end
                default:
                begin
                    w.push_back(U_RING);
                    w.push_back(CH_V);
                end
            endcase
        end
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(1, 5))
                5:
                begin
                    for (int k = 0; k < 5; k++)
                        w.push_back(SFX5[k]);
                end
                4:
                begin
                    i = $urandom_range(0, 2);
                    for (int k = 0; k < 4; k++)
                        w.push_back(SFX4[i][k]);
                end
                3:
                begin
                    i = $urandom_range(0, 24);
                    for (int k = 0; k < 3; k++)
                        w.push_back(SFX3[i][k]);
                end
                2:
                begin
                    i = $urandom_range(0, 11);
                    for (int k = 0; k < 2; k++)
                        w.push_back(SFX2[i][k]);
                end
                default:
                    w.push_back(VOWELS[$urandom_range(0, 11)]);
            endcase
        end
        if (w.size() == 0)
            w.push_back(pick_char());
        calm = ($urandom_range(0, 5) == 0);
        send_word(w);
    endtask

    // receiver: draw a stall per beat, then hold ready until a beat moves
    initial
    begin : sink
        int gap;
        stem_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                stem_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            stem_ready <= 1'b1;
            do
                @(posedge clk);
            while (!stem_valid);
        end
    end

    initial
    begin : source
        logic [15:0] w [$];
        rst_n      <= 1'b0;
        char_valid <= 1'b0;
        char_data  <= '0;
        calm       = 1'b0;
        chars_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a one-character and a two-character word at the extremes of the character range
        send_word('{16'hFFFF});
        send_word('{16'h0000, Z_CARON});
        // case ending atech, then the e ahead of the last character goes
        send_word('{CH_S, CH_E, CH_S, CH_A, CH_T, CH_E, CH_C, CH_H});
        // u-ring ahead of the last character becomes o
        send_word('{CH_S, CH_T, U_RING, 16'h006C});
        // c-caron t becomes ck
        send_word('{CH_M, CH_E, C_CARON, CH_T});
        // repaired four-character ending with u-ring
        send_word('{CH_K, CH_O, CH_S, CH_A, CH_T, U_RING, CH_M});
        drain();

        // saturating length: true ending still drives every pass
        calm = 1'b1;
        w.delete();
        repeat (65540) w.push_back(pick_char());
        w = {w, C_CARON, CH_T, CH_O, CH_V, CH_A, CH_T, CH_E, CH_C, CH_H};
        send_word(w);
        drain();

        chars_sent = 0;
        while (chars_sent < 1600)
            send_random_word();
        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && stems_owed == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
